FILE: sv/qtd_pkg.sv
`timescale 1ns / 1ps
package qtd_pkg;

  // expression bytes
  localparam logic [7:0] SYM_END   = 8'h00;
  localparam logic [7:0] SYM_BLACK = 8'h31;
  localparam logic [7:0] SYM_SPLIT = 8'h32;

  localparam int MAX_LOG2      = 10;
  localparam int MAX_DEPTH_DEF = 16;

  localparam int SYM_W   = 8;
  localparam int LOG2_W  = 4;
  localparam int COORD_W = 10;
  localparam int SIDE_W  = 11;
  localparam int PIX_W   = 21;

  localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd3;

  // register indexes
  localparam logic REG_IMAGE_LOG2 = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture the incoming item
    logic commit;  // update state, load the result register if needed
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;
  } dp_sts_t;

endpackage

FILE: sv/qtd_ctrl.sv
`timescale 1ns / 1ps
module qtd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output qtd_pkg::dp_cmd_t cmd,
  input  qtd_pkg::dp_sts_t sts
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.latch  = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit = (state_r == ST_EXEC) && (!sts.has_result || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.commit) begin
            state_r <= ST_IDLE;
            if (sts.has_result) begin
              out_valid_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit && sts.has_result))
    else $error("result shown without a commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.has_result) |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_latch_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !cmd.latch)
    else $error("item taken while another is in flight");
`endif

endmodule

FILE: sv/qtd_dp.sv
`timescale 1ns / 1ps
module qtd_dp #(
  parameter int MAX_DEPTH = qtd_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qtd_pkg::dp_cmd_t             cmd,
  output qtd_pkg::dp_sts_t             sts,
  input  logic [qtd_pkg::SYM_W-1:0]    in_symbol,
  input  logic                         in_first,
  input  logic                         cfg_we,
  input  logic [qtd_pkg::LOG2_W-1:0]   cfg_wdata,
  output logic [qtd_pkg::LOG2_W-1:0]   image_log2,
  output logic [qtd_pkg::COORD_W-1:0]  out_square_x,
  output logic [qtd_pkg::COORD_W-1:0]  out_square_y,
  output logic [qtd_pkg::SIDE_W-1:0]   out_square_side,
  output logic                         out_is_black,
  output logic                         out_done_res,
  output logic [qtd_pkg::PIX_W-1:0]    out_black_pixels,
  output logic                         out_overflow
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = $clog2(MAX_DEPTH);

  logic [1:0]                      stack_r [MAX_DEPTH];
  logic [LVL_W-1:0]                level_r, level_nxt, eff_level;
  logic                            finished_r, finished_nxt;
  logic [qtd_pkg::PIX_W-1:0]       total_r, total_nxt, eff_total, area;
  logic [qtd_pkg::LOG2_W-1:0]      log2_r, lg, sh;
  logic [qtd_pkg::SYM_W-1:0]       sym_r;
  logic                            first_r;

  logic [qtd_pkg::COORD_W-1:0]     sq_x, sq_y, x_r, y_r;
  logic [qtd_pkg::SIDE_W-1:0]      side, side_r;
  logic                            black_r, done_r, ovf_r;
  logic [qtd_pkg::PIX_W-1:0]       pix_r;

  logic                            skip, leaf_black, found;
  logic [IDX_W-1:0]                top;
  logic                            push, inc;
  logic                            res_valid, res_black, res_done, res_ovf;

  assign image_log2 = log2_r;
  assign lg = (int'(log2_r) > qtd_pkg::MAX_LOG2) ?
              qtd_pkg::LOG2_W'(qtd_pkg::MAX_LOG2) : log2_r;

  assign skip      = !first_r && finished_r;
  assign eff_level = first_r ? '0 : level_r;
  assign eff_total = first_r ? '0 : total_r;

  // side and area of the current square; side is zero once below one pixel
  assign sh         = qtd_pkg::LOG2_W'(int'(lg) - int'(eff_level));
  assign side       = (int'(eff_level) > int'(lg)) ? '0 : (qtd_pkg::SIDE_W'(1) << sh);
  assign area       = qtd_pkg::PIX_W'(1) << {sh, 1'b0};
  assign leaf_black = (sym_r == qtd_pkg::SYM_BLACK) && (side != '0);

  // corner: level i sets coordinate bit lg-1-i
  always_comb begin
    sq_x = '0;
    sq_y = '0;
    for (int b = 0; b < qtd_pkg::COORD_W; b++) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if ((int'(lg) == b + i + 1) && (i < int'(eff_level))) begin
          sq_x[b] = stack_r[i][1];
          sq_y[b] = stack_r[i][0];
        end
      end
    end
  end

  // deepest open level with a sibling left
  always_comb begin
    found = 1'b0;
    top   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((i < int'(eff_level)) && (stack_r[i] != 2'd3)) begin
        found = 1'b1;
        top   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    level_nxt    = level_r;
    finished_nxt = finished_r;
    total_nxt    = total_r;
    push         = 1'b0;
    inc          = 1'b0;
    res_valid    = 1'b0;
    res_black    = 1'b0;
    res_done     = 1'b0;
    res_ovf      = 1'b0;
    if (!skip) begin
      level_nxt    = eff_level;
      finished_nxt = 1'b0;
      total_nxt    = eff_total;
      if (sym_r == qtd_pkg::SYM_END) begin
        finished_nxt = 1'b1;
        res_valid    = 1'b1;
        res_done     = 1'b1;
      end else if (sym_r == qtd_pkg::SYM_SPLIT) begin
        if (int'(eff_level) >= MAX_DEPTH) begin
          finished_nxt = 1'b1;
          res_valid    = 1'b1;
          res_done     = 1'b1;
          res_ovf      = 1'b1;
        end else begin
          push      = 1'b1;
          level_nxt = eff_level + LVL_W'(1);
        end
      end else begin
        if (leaf_black) begin
          total_nxt = eff_total + area;
          res_black = 1'b1;
        end
        if (found) begin
          inc       = 1'b1;
          level_nxt = LVL_W'(top) + LVL_W'(1);
        end else begin
          level_nxt    = '0;
          finished_nxt = 1'b1;
          res_done     = 1'b1;
        end
        res_valid = res_black || !found;
      end
    end
  end

  assign sts.has_result = res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        stack_r[i] <= '0;
      end
      level_r    <= '0;
      finished_r <= 1'b1;
      total_r    <= '0;
      log2_r     <= qtd_pkg::LOG2_RESET;
    end else begin
      if (cfg_we) begin
        log2_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        level_r    <= level_nxt;
        finished_r <= finished_nxt;
        total_r    <= total_nxt;
        if (push) begin
          stack_r[eff_level[IDX_W-1:0]] <= 2'd0;
        end
        if (inc) begin
          stack_r[top] <= stack_r[top] + 2'd1;
        end
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym_r   <= in_symbol;
      first_r <= in_first;
    end
    if (cmd.commit && res_valid) begin
      x_r     <= res_black ? sq_x : '0;
      y_r     <= res_black ? sq_y : '0;
      side_r  <= res_black ? side : '0;
      black_r <= res_black;
      done_r  <= res_done;
      ovf_r   <= res_ovf;
      pix_r   <= total_nxt;
    end
  end

  assign out_square_x     = x_r;
  assign out_square_y     = y_r;
  assign out_square_side  = side_r;
  assign out_is_black     = black_r;
  assign out_done_res     = done_r;
  assign out_black_pixels = pix_r;
  assign out_overflow     = ovf_r;

endmodule

FILE: sv/quadtree_expression_decoder.sv
`timescale 1ns / 1ps
// Quadtree expression decoder: one expression byte per item, black squares out.
// An accepted item is captured, then decoded and unwound in the exec state, where
// the result register loads if it gives a result; no new item is taken until then,
// and exec waits only while the result register is full and the output is stalled.
// Reset (rst_n, synchronous, active low): stack, level and pixel count cleared,
// block waiting for a first item, image_log2 back to 3.
module quadtree_expression_decoder #(
  parameter int MAX_DEPTH = qtd_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [qtd_pkg::SYM_W-1:0]    in_symbol,
  input  logic                         in_first,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [qtd_pkg::COORD_W-1:0]  out_square_x,
  output logic [qtd_pkg::COORD_W-1:0]  out_square_y,
  output logic [qtd_pkg::SIDE_W-1:0]   out_square_side,
  output logic                         out_is_black,
  output logic                         out_done_res,
  output logic [qtd_pkg::PIX_W-1:0]    out_black_pixels,
  output logic                         out_overflow,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  qtd_pkg::dp_cmd_t            cmd;
  qtd_pkg::dp_sts_t            sts;
  logic                        cfg_we;
  logic [qtd_pkg::LOG2_W-1:0]  image_log2;

  // Register map: image_log2 at byte address 0; paddr[2] picks the register,
  // writes elsewhere are dropped and read back as zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == qtd_pkg::REG_IMAGE_LOG2);
  assign prdata = (paddr[2] == qtd_pkg::REG_IMAGE_LOG2) ? 32'(image_log2) : '0;

  // Sequencer: idle -> exec, waits in exec only while a result cannot be stored.
  qtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Child stack, level, pixel count, corner/side logic and the result register.
  qtd_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_symbol        (in_symbol),
    .in_first         (in_first),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[qtd_pkg::LOG2_W-1:0]),
    .image_log2       (image_log2),
    .out_square_x     (out_square_x),
    .out_square_y     (out_square_y),
    .out_square_side  (out_square_side),
    .out_is_black     (out_is_black),
    .out_done_res     (out_done_res),
    .out_black_pixels (out_black_pixels),
    .out_overflow     (out_overflow)
  );

endmodule
